// ===== rtl/core/qte_pkg.sv =====
package qte_pkg;

    // Default number of CORDIC micro-rotations, and the size of the arctangent table.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    // Width of the Q.30 sums, of the CORDIC datapath and of its angle accumulator.
    localparam int SUM_W  = 34;
    localparam int CRD_W  = 36;
    localparam int ANG_W  = 34;

    // Square root: one result bit per stage over a 62-bit radicand.
    localparam int SQRT_STEPS = 31;
    localparam int RAD_W      = 62;
    localparam int ROOT_W     = 31;

    // Fixed-point constants: 1.0 in Q.30, and +-pi/2 as 16-bit binary angles.
    localparam logic signed [SUM_W-1:0] ONE_Q30   = SUM_W'(64'sd1 << 30);
    localparam logic signed [SUM_W-1:0] M_ONE_Q30 = -ONE_Q30;
    localparam logic signed [15:0]      HALF_PI   = 16'sd16384;
    localparam logic signed [15:0]      M_HALF_PI = -16'sd16384;

    // atan(2^-i) as a 32-bit binary angle (2^31 = pi).
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Sums and flags that travel beside the square root.
    typedef struct packed {
        logic signed [SUM_W-1:0]  sinr;
        logic signed [SUM_W-1:0]  cosr;
        logic signed [SUM_W-1:0]  siny;
        logic signed [SUM_W-1:0]  cosy;
        logic signed [ROOT_W-1:0] sinp;
        logic                     sat_pos;
        logic                     sat_neg;
    } t_side;

    // Pitch clamp flags carried through the CORDIC stages.
    typedef struct packed {
        logic sat_pos;
        logic sat_neg;
    } t_sat;

endpackage

// ===== rtl/core/qte_if.sv =====
// Quaternion item channel.
interface qte_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// Euler angle item channel.
interface qte_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_saturated;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
                    output ready);
endinterface

// ===== rtl/core/qte_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qte_isqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [qte_pkg::RAD_W-1:0]       i_rad,
    output logic [qte_pkg::ROOT_W-1:0]      o_root
);
    localparam int N = qte_pkg::SQRT_STEPS;
    localparam int W = qte_pkg::RAD_W;

    logic [W-1:0] r_v   [N];
    logic [W-1:0] r_res [N];

    for (genvar j = 0; j < N; j++) begin : g_step
        localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - j));
        logic [W-1:0] v_in;
        logic [W-1:0] res_in;
        logic [W-1:0] trial;
        logic [W-1:0] n_v;
        logic [W-1:0] n_res;

        if (j == 0) begin : g_first
            assign v_in   = i_rad;
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_v[j-1];
            assign res_in = r_res[j-1];
        end

        // Try to subtract the candidate; keep the result bit where it fits.
        always_comb begin
            trial = res_in + BIT;
            if (v_in >= trial) begin
                n_v   = v_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_v   = v_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[j]   <= n_v;
                r_res[j] <= n_res;
            end
        end
    end

    assign o_root = r_res[N-1][qte_pkg::ROOT_W-1:0];
endmodule

// ===== rtl/core/qte_cordic.sv =====
// Pipelined CORDIC in vectoring mode: atan2(y, x) as a 16-bit binary angle.
module qte_cordic #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [qte_pkg::SUM_W-1:0] i_x,
    input  logic signed [qte_pkg::SUM_W-1:0] i_y,
    output logic signed [15:0]               o_angle
);
    localparam int CW = qte_pkg::CRD_W;
    localparam int AW = qte_pkg::ANG_W;
    localparam int IW = qte_pkg::SUM_W;
    localparam logic signed [AW-1:0] QUARTER = AW'(64'sd1 << 30);

    logic signed [CW-1:0] r_x    [CORDIC_STAGES+1];
    logic signed [CW-1:0] r_y    [CORDIC_STAGES+1];
    logic signed [AW-1:0] r_z    [CORDIC_STAGES+1];
    logic                 r_zero [CORDIC_STAGES+1];
    logic signed [15:0]   r_angle;

    logic signed [CW-1:0] x_ext;
    logic signed [CW-1:0] y_ext;
    logic signed [CW-1:0] n_x0;
    logic signed [CW-1:0] n_y0;
    logic signed [AW-1:0] n_z0;

    assign x_ext = CW'(i_x);
    assign y_ext = CW'(i_y);

    // Turn a vector in the left half plane by a quarter turn.
    always_comb begin
        n_x0 = x_ext;
        n_y0 = y_ext;
        n_z0 = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = y_ext;
                n_y0 = -x_ext;
                n_z0 = QUARTER;
            end else begin
                n_x0 = -y_ext;
                n_y0 = x_ext;
                n_z0 = -QUARTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == IW'(0)) && (i_y == IW'(0));
        end
    end

    // Micro-rotations, each steering y toward zero.
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [AW-1:0] ATAN = AW'(qte_pkg::ATAN_TAB[i]);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [AW-1:0] n_z;

        always_comb begin
            xs = r_x[i] >>> i;
            ys = r_y[i] >>> i;
            if (r_y[i] > 0) begin
                n_x = r_x[i] + ys;
                n_y = r_y[i] - xs;
                n_z = r_z[i] + ATAN;
            end else begin
                n_x = r_x[i] - ys;
                n_y = r_y[i] + xs;
                n_z = r_z[i] - ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_z;
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    // Round half up to 16 bits; a null vector gives angle zero.
    logic signed [AW-1:0] z_rnd;
    assign z_rnd = r_z[CORDIC_STAGES] + AW'(32768);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= r_zero[CORDIC_STAGES] ? 16'sd0 : z_rnd[31:16];
        end
    end

    assign o_angle = r_angle;
endmodule

// ===== rtl/core/quaternion_to_euler.sv =====
// Quaternion to Z-Y-X Euler angle converter.
// Input channel i_quat carries one unit quaternion (x, y, z, w) per item, each
// component signed Q1.15. Output channel o_euler carries roll, pitch and yaw as
// signed 16-bit binary angles (32768 = pi) and a flag that is set when the pitch
// argument reached one in magnitude and pitch was clamped to plus or minus pi/2.
// Both channels use valid/ready; an item moves when both are high.
// The block is a straight pipeline and takes one item every cycle while the
// output does not stall. Its stages are the products, the sums, the square of
// the pitch sine and the radicand, 31 pipelined square-root stages for the pitch
// cosine, one result bit each, a quarter-turn stage, the CORDIC stages and rounding.
// When the receiver holds ready low while a result waits, the whole pipeline
// freezes and i_quat.ready drops; nothing is lost or repeated, and bubbles
// between items are kept as they are.
// Reset (i_rst_n low at a clock edge) empties the pipeline; no item is
// delivered from before reset.
module quaternion_to_euler #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler
);
    localparam int SW   = qte_pkg::SUM_W;
    localparam int RW   = qte_pkg::ROOT_W;
    localparam int SQN  = qte_pkg::SQRT_STEPS;
    localparam int LAT  = 37 + CORDIC_STAGES;
    localparam int SIDE = SQN + 2;
    localparam int FLG  = CORDIC_STAGES + 2;

    logic en;
    logic [LAT:1] r_vld;

    assign en           = !r_vld[LAT] || o_euler.ready;
    assign i_quat.ready = en;

    // Valid bits walk with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:1], i_quat.valid};
        end
    end

    // Stage 1: component products.
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= i_quat.quat_w * i_quat.quat_x;
            r_yz <= i_quat.quat_y * i_quat.quat_z;
            r_xx <= i_quat.quat_x * i_quat.quat_x;
            r_yy <= i_quat.quat_y * i_quat.quat_y;
            r_wz <= i_quat.quat_w * i_quat.quat_z;
            r_xy <= i_quat.quat_x * i_quat.quat_y;
            r_zz <= i_quat.quat_z * i_quat.quat_z;
            r_wy <= i_quat.quat_w * i_quat.quat_y;
            r_zx <= i_quat.quat_z * i_quat.quat_x;
        end
    end

    // Stage 2: the five Q.30 arguments.
    logic signed [SW-1:0] r_sinr, r_cosr, r_siny, r_cosy, r_sinp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sinr <= (SW'(r_wx) + SW'(r_yz)) <<< 1;
            r_cosr <= qte_pkg::ONE_Q30 - ((SW'(r_xx) + SW'(r_yy)) <<< 1);
            r_siny <= (SW'(r_wz) + SW'(r_xy)) <<< 1;
            r_cosy <= qte_pkg::ONE_Q30 - ((SW'(r_yy) + SW'(r_zz)) <<< 1);
            r_sinp <= (SW'(r_wy) - SW'(r_zx)) <<< 1;
        end
    end

    // Stage 3: clamp test and square of the pitch sine; side data starts here.
    qte_pkg::t_side r_side [SIDE];
    logic signed [RW-1:0]   sinp_n;
    logic signed [2*RW-1:0] r_sq;

    assign sinp_n = r_sinp[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq                <= sinp_n * sinp_n;
            r_side[0].sinr      <= r_sinr;
            r_side[0].cosr      <= r_cosr;
            r_side[0].siny      <= r_siny;
            r_side[0].cosy      <= r_cosy;
            r_side[0].sinp      <= sinp_n;
            r_side[0].sat_pos   <= r_sinp >= qte_pkg::ONE_Q30;
            r_side[0].sat_neg   <= r_sinp <= qte_pkg::M_ONE_Q30;
        end
    end

    for (genvar k = 1; k < SIDE; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Stage 4: radicand 1 - sin^2 in Q.60.
    logic [qte_pkg::RAD_W-1:0] r_rad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad <= (qte_pkg::RAD_W'(1) << 60) - qte_pkg::RAD_W'(r_sq[59:0]);
        end
    end

    // Pitch cosine by square root.
    logic [RW-1:0] root;

    qte_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_rad),
        .o_root (root)
    );

    // Three CORDIC lanes fed from the aligned side data and root.
    qte_pkg::t_side side_q;
    logic signed [15:0] roll_ang, pitch_ang, yaw_ang;

    assign side_q = r_side[SIDE-1];

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (side_q.cosr),
        .i_y     (side_q.sinr),
        .o_angle (roll_ang)
    );

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (SW'({1'b0, root})),
        .i_y     (SW'(side_q.sinp)),
        .o_angle (pitch_ang)
    );

    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (side_q.cosy),
        .i_y     (side_q.siny),
        .o_angle (yaw_ang)
    );

    // Clamp flags follow the CORDIC latency.
    qte_pkg::t_sat r_flg [FLG];

    for (genvar f = 0; f < FLG; f++) begin : g_flg
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (f == 0) begin
                    r_flg[f] <= '{sat_pos: side_q.sat_pos, sat_neg: side_q.sat_neg};
                end else begin
                    r_flg[f] <= r_flg[(f == 0) ? 0 : f-1];
                end
            end
        end
    end

    // Output item.
    qte_pkg::t_sat flg_q;
    assign flg_q = r_flg[FLG-1];

    assign o_euler.valid           = r_vld[LAT];
    assign o_euler.roll_angle      = roll_ang;
    assign o_euler.yaw_angle       = yaw_ang;
    assign o_euler.pitch_saturated = flg_q.sat_pos || flg_q.sat_neg;
    assign o_euler.pitch_angle     = flg_q.sat_pos ? qte_pkg::HALF_PI :
                                     flg_q.sat_neg ? qte_pkg::M_HALF_PI : pitch_ang;
endmodule
